/* rtl/core/bbr_pkg.sv */
// Shared types and constants for the box blur stream core.
package bbr_pkg;

   localparam int MaxKernel = 15;
   localparam int MaxWidth  = 2048;
   localparam int MaxHeight = 4096;
   localparam int RingRows  = 16;
   localparam int ColW      = 11;
   localparam int RowSelW   = 4;
   localparam int AddrW     = RowSelW + ColW;
   localparam int PixW      = 32;
   localparam int SumW      = 16;
   localparam int DivCntW   = $clog2(SumW);

   localparam logic [1:0] CSR_KERNEL = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_CHECK,
      ST_CENTER,
      ST_READ,
      ST_DRAIN,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

endpackage

/* rtl/core/bbr_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
module bbr_ram #(
   parameter int ADDR_W = 15,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/bbr_div.sv */
// Three-lane restoring divider, one quotient bit per cycle.
module bbr_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bbr_pkg::SumW-1:0]      dividend_r,
   input  logic [bbr_pkg::SumW-1:0]      dividend_g,
   input  logic [bbr_pkg::SumW-1:0]      dividend_b,
   input  logic [7:0]                    divisor,
   output logic                          done,
   output logic [7:0]                    quot_r,
   output logic [7:0]                    quot_g,
   output logic [7:0]                    quot_b
);

   logic [bbr_pkg::SumW-1:0]    dvd_ff [3];
   logic [bbr_pkg::SumW-1:0]    dvd_in [3];
   logic [7:0]                  rem_ff [3];
   logic [7:0]                  rem_in [3];
   logic [7:0]                  dsr_ff;
   logic [bbr_pkg::DivCntW-1:0] cnt_ff;
   logic                        busy_ff;
   logic                        done_ff;

   always_comb begin
      logic [8:0] trial;
      for (int n = 0; n < 3; n++) begin
         trial = {rem_ff[n], dvd_ff[n][bbr_pkg::SumW-1]};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in[n] = 8'(trial - {1'b0, dsr_ff});
            dvd_in[n] = {dvd_ff[n][bbr_pkg::SumW-2:0], 1'b1};
         end else begin
            rem_in[n] = trial[7:0];
            dvd_in[n] = {dvd_ff[n][bbr_pkg::SumW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + bbr_pkg::DivCntW'(1);
            if (cnt_ff == bbr_pkg::DivCntW'(bbr_pkg::SumW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff[0] <= dividend_r;
         dvd_ff[1] <= dividend_g;
         dvd_ff[2] <= dividend_b;
         for (int n = 0; n < 3; n++) begin
            rem_ff[n] <= '0;
         end
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         for (int n = 0; n < 3; n++) begin
            dvd_ff[n] <= dvd_in[n];
            rem_ff[n] <= rem_in[n];
         end
      end
   end

   assign done   = done_ff;
   assign quot_r = dvd_ff[0][7:0];
   assign quot_g = dvd_ff[1][7:0];
   assign quot_b = dvd_ff[2][7:0];

endmodule

/* rtl/core/box_blur_rgb_stream_core.sv */
// Top level of the streaming zero-padded RGBA box blur.
// A transaction that yields no output pixel passes only through the write and check states.
// One that yields a pixel also reads the window one pixel per cycle from the line store,
// then a 16-step divider runs, and the result may wait on a result stall.
// The core stalls new requests until the transaction returns it to idle.
// Synchronous active-high reset restores the default registers and clears the stream position counters.
module box_blur_rgb_stream_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic [7:0]  req_alpha_in,
   input  logic        req_flush,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic [7:0]  rsp_alpha_out,
   output logic        rsp_last_pixel,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);

   bbr_pkg::state_type state_ff, state_in;

   logic [3:0]  kernel_ff;
   logic [11:0] width_ff;
   logic [12:0] height_ff;

   logic [3:0]  k_ff;
   logic [11:0] w_ff;
   logic [12:0] h_ff;
   logic [23:0] total_ff;
   logic [14:0] lag_ff;
   logic [7:0]  dsr_ff;

   logic [bbr_pkg::ColW-1:0] col_ff, col_in;
   logic [12:0]              row_ff, row_in;
   logic [23:0]              rcv_ff, rcv_in;
   logic [23:0]              oidx_ff, oidx_in;
   logic [bbr_pkg::ColW-1:0] ocol_ff, ocol_in;
   logic [11:0]              orow_ff, orow_in;

   logic [31:0] pix_ff;
   logic        flush_ff;
   logic [3:0]  wi_ff, wi_in;
   logic [3:0]  wj_ff, wj_in;
   logic        acc_pend_ff, acc_pend_in;
   logic        ctr_pend_ff, ctr_pend_in;
   logic [bbr_pkg::SumW-1:0] sr_ff, sg_ff, sb_ff;
   logic [7:0]  alpha_ff;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_r_ff, rsp_g_ff, rsp_b_ff, rsp_a_ff;
   logic        rsp_last_ff;

   logic                     wr_en;
   logic [bbr_pkg::AddrW-1:0] wr_addr;
   logic [bbr_pkg::AddrW-1:0] rd_addr;
   logic [31:0]              rd_data;
   logic                     cfg_wr;
   logic                     restart;
   logic                     out_free;
   logic                     load_out;
   logic                     in_win;
   logic signed [13:0]       yy;
   logic signed [12:0]       xx;
   logic [2:0]               back;
   logic [2:0]               fwd;
   logic [11:0]              w_lim;
   logic [12:0]              h_lim;
   logic [7:0]               q_r, q_g, q_b;
   logic                     div_start;
   logic                     div_done;

   assign csr_ready = 1'b1;
   assign cfg_wr    = csr_valid && csr_ready;
   assign req_stall = (state_ff != bbr_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= 4'd3;
         width_ff  <= 12'd640;
         height_ff <= 13'd480;
      end else if (cfg_wr) begin
         case (csr_index)
            bbr_pkg::CSR_KERNEL: kernel_ff <= csr_data[3:0];
            bbr_pkg::CSR_WIDTH:  width_ff  <= csr_data[11:0];
            bbr_pkg::CSR_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      w_lim = (width_ff == 12'd0) ? 12'd1 :
              (width_ff > 12'(bbr_pkg::MaxWidth)) ? 12'(bbr_pkg::MaxWidth) : width_ff;
      h_lim = (height_ff == 13'd0) ? 13'd1 :
              (height_ff > 13'(bbr_pkg::MaxHeight)) ? 13'(bbr_pkg::MaxHeight) : height_ff;
      back  = k_ff[3:1];
      fwd   = 3'(k_ff - 4'd1 - {1'b0, back});
   end

   always_ff @(posedge clock) begin
      k_ff     <= (kernel_ff == 4'd0) ? 4'd1 : kernel_ff;
      w_ff     <= w_lim;
      h_ff     <= h_lim;
      total_ff <= 24'(w_ff) * 24'(h_ff);
      lag_ff   <= 15'(fwd) * 15'(w_ff) + 15'(fwd);
      dsr_ff   <= {4'd0, k_ff} * {4'd0, k_ff};
   end

   always_comb begin
      yy = $signed({2'b00, orow_ff}) + $signed({10'd0, wi_ff}) - $signed({11'd0, back});
      xx = $signed({2'b00, ocol_ff}) + $signed({9'd0, wj_ff}) - $signed({10'd0, back});
      in_win = !yy[13] && (yy[12:0] < h_ff) && !xx[12] && (xx[11:0] < w_ff);
   end

   always_comb begin
      state_in    = state_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      rcv_in      = rcv_ff;
      oidx_in     = oidx_ff;
      ocol_in     = ocol_ff;
      orow_in     = orow_ff;
      wi_in       = wi_ff;
      wj_in       = wj_ff;
      acc_pend_in = 1'b0;
      ctr_pend_in = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = {row_ff[bbr_pkg::RowSelW-1:0], col_ff};
      rd_addr     = {yy[bbr_pkg::RowSelW-1:0], xx[bbr_pkg::ColW-1:0]};
      div_start   = 1'b0;
      load_out    = 1'b0;
      restart     = 1'b0;
      case (state_ff)
         bbr_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = bbr_pkg::ST_WRITE;
            end
         end
         bbr_pkg::ST_WRITE: begin
            if (!flush_ff && (row_ff < h_ff)) begin
               wr_en  = 1'b1;
               rcv_in = rcv_ff + 24'd1;
               if ({1'b0, col_ff} + 12'd1 >= w_ff) begin
                  col_in = '0;
                  row_in = row_ff + 13'd1;
               end else begin
                  col_in = col_ff + 11'd1;
               end
            end
            state_in = bbr_pkg::ST_CHECK;
         end
         bbr_pkg::ST_CHECK: begin
            wi_in = '0;
            wj_in = '0;
            if ((oidx_ff < total_ff) &&
                ((row_ff >= h_ff) ||
                 ({1'b0, rcv_ff} >= {1'b0, oidx_ff} + {10'd0, lag_ff} + 25'd1))) begin
               state_in = bbr_pkg::ST_CENTER;
            end else begin
               state_in = bbr_pkg::ST_IDLE;
            end
         end
         bbr_pkg::ST_CENTER: begin
            rd_addr     = {orow_ff[bbr_pkg::RowSelW-1:0], ocol_ff};
            ctr_pend_in = 1'b1;
            state_in    = bbr_pkg::ST_READ;
         end
         bbr_pkg::ST_READ: begin
            acc_pend_in = in_win;
            if (wj_ff == k_ff - 4'd1) begin
               wj_in = '0;
               if (wi_ff == k_ff - 4'd1) begin
                  state_in = bbr_pkg::ST_DRAIN;
               end else begin
                  wi_in = wi_ff + 4'd1;
               end
            end else begin
               wj_in = wj_ff + 4'd1;
            end
         end
         bbr_pkg::ST_DRAIN: begin
            state_in = bbr_pkg::ST_DIV_START;
         end
         bbr_pkg::ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = bbr_pkg::ST_DIV_WAIT;
         end
         bbr_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = bbr_pkg::ST_OUT;
            end
         end
         bbr_pkg::ST_OUT: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = bbr_pkg::ST_IDLE;
               if (oidx_ff == total_ff - 24'd1) begin
                  restart = 1'b1;
               end else begin
                  oidx_in = oidx_ff + 24'd1;
                  if ({1'b0, ocol_ff} + 12'd1 >= w_ff) begin
                     ocol_in = '0;
                     orow_in = orow_ff + 12'd1;
                  end else begin
                     ocol_in = ocol_ff + 11'd1;
                  end
               end
            end
         end
         default: begin
            state_in = bbr_pkg::ST_IDLE;
         end
      endcase
      if (restart || (cfg_wr && (csr_index == bbr_pkg::CSR_KERNEL ||
                                 csr_index == bbr_pkg::CSR_WIDTH ||
                                 csr_index == bbr_pkg::CSR_HEIGHT))) begin
         col_in  = '0;
         row_in  = '0;
         rcv_in  = '0;
         oidx_in = '0;
         ocol_in = '0;
         orow_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bbr_pkg::ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         rcv_ff       <= '0;
         oidx_ff      <= '0;
         ocol_ff      <= '0;
         orow_ff      <= '0;
         acc_pend_ff  <= 1'b0;
         ctr_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         rcv_ff      <= rcv_in;
         oidx_ff     <= oidx_in;
         ocol_ff     <= ocol_in;
         orow_ff     <= orow_in;
         acc_pend_ff <= acc_pend_in;
         ctr_pend_ff <= ctr_pend_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      wi_ff <= wi_in;
      wj_ff <= wj_in;
      if (req_valid && !req_stall) begin
         pix_ff   <= {req_alpha_in, req_blue_in, req_green_in, req_red_in};
         flush_ff <= req_flush;
      end
      if (state_ff == bbr_pkg::ST_CENTER) begin
         sr_ff <= '0;
         sg_ff <= '0;
         sb_ff <= '0;
      end else if (acc_pend_ff) begin
         sr_ff <= sr_ff + {8'd0, rd_data[7:0]};
         sg_ff <= sg_ff + {8'd0, rd_data[15:8]};
         sb_ff <= sb_ff + {8'd0, rd_data[23:16]};
      end
      if (ctr_pend_ff) begin
         alpha_ff <= rd_data[31:24];
      end
      if (load_out) begin
         rsp_r_ff    <= q_r;
         rsp_g_ff    <= q_g;
         rsp_b_ff    <= q_b;
         rsp_a_ff    <= alpha_ff;
         rsp_last_ff <= restart;
      end
   end

   bbr_ram #(
      .ADDR_W(bbr_pkg::AddrW),
      .DATA_W(bbr_pkg::PixW)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (pix_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bbr_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend_r (sr_ff),
      .dividend_g (sg_ff),
      .dividend_b (sb_ff),
      .divisor    (dsr_ff),
      .done       (div_done),
      .quot_r     (q_r),
      .quot_g     (q_g),
      .quot_b     (q_b)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_out    = rsp_r_ff;
   assign rsp_green_out  = rsp_g_ff;
   assign rsp_blue_out   = rsp_b_ff;
   assign rsp_alpha_out  = rsp_a_ff;
   assign rsp_last_pixel = rsp_last_ff;

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == bbr_pkg::ST_DIV_WAIT)
      else $error("divider finished outside its wait state");

   a_write_only_in_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == bbr_pkg::ST_WRITE)
      else $error("line store written outside the write state");

   a_acc_after_read: assert property (@(posedge clock) disable iff (reset)
      acc_pend_ff |-> $past(state_ff == bbr_pkg::ST_READ))
      else $error("window accumulation without a preceding read");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output register overwritten while a transaction waits");

endmodule
